[rtl/crf_pkg.sv]
package crf_pkg;

    localparam int OP_W     = 3;
    localparam int WORD_W   = 32;
    localparam int STATUS_W = 2;
    localparam int FILL_W   = 8;
    localparam int PROD_W   = 8;
    localparam int WIDE_W   = 64;

    localparam logic [OP_W-1:0] OP_PUSH   = 3'd0;
    localparam logic [OP_W-1:0] OP_POP    = 3'd1;
    localparam logic [OP_W-1:0] OP_CLOSE  = 3'd2;
    localparam logic [OP_W-1:0] OP_ABORT  = 3'd3;
    localparam logic [OP_W-1:0] OP_CLEAR  = 3'd4;
    localparam logic [OP_W-1:0] OP_LENGTH = 3'd5;

    localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CLOSED = 2'd3;

    localparam logic [PROD_W-1:0] PROD_RESET = 8'd1;

    typedef struct packed {
        logic                valid;
        logic [STATUS_W-1:0] status;
        logic [FILL_W-1:0]   fill_count;
        logic                is_closed;
        logic                pop_ok;
    } crf_result_t;

    typedef struct packed {
        logic closed;
        logic aborted;
        logic full;
        logic empty;
    } crf_flags_t;

endpackage

[rtl/crf_cmd_if.sv]
interface crf_cmd_if;
    import crf_pkg::*;

    logic              valid;
    logic              ready;
    logic [OP_W-1:0]   op;
    logic [WORD_W-1:0] push_data;

    modport source (output valid, output op, output push_data, input ready);
    modport sink (input valid, input op, input push_data, output ready);

endinterface

[rtl/crf_rsp_if.sv]
interface crf_rsp_if;
    import crf_pkg::*;

    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [WORD_W-1:0]   pop_data;
    logic [FILL_W-1:0]   fill_count;
    logic                is_closed;

    modport source (
        output valid, output status, output pop_data, output fill_count,
        output is_closed, input ready
    );
    modport sink (
        input valid, input status, input pop_data, input fill_count,
        input is_closed, output ready
    );

endinterface

[rtl/closable_ring_fifo.sv]
// channel | role   | handshake           | payload
// cmd     | sink   | valid / ready       | op, push_data
// rsp     | source | valid / ready       | status, pop_data, fill_count, is_closed
// cfg     | sink   | cfg_wr_en, no ready | cfg_wr_data (producer count)
//
// one transaction per cycle while cmd.ready; each result comes in the next cycle
// the entry memory has one write and one read port, read data registered,
// so a pop word arrives with the result register in the cycle after acceptance
// cmd.ready falls only while a result is held with rsp.ready low
// reset clears pointers, fill, flags and loads one producer; entries are not cleared
module closable_ring_fifo #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       cfg_wr_en,
    input  logic [crf_pkg::PROD_W-1:0] cfg_wr_data,
    crf_cmd_if.sink                    cmd,
    crf_rsp_if.source                  rsp
);
    import crf_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);

    crf_result_t           result;
    crf_flags_t            flags;
    logic                  mem_wr_en;
    logic [ADDR_W-1:0]     mem_wr_addr;
    logic                  mem_rd_en;
    logic [ADDR_W-1:0]     mem_rd_addr;
    logic [DATA_WIDTH-1:0] mem_wr_data;
    logic [DATA_WIDTH-1:0] mem_rd_data;
    logic [WIDE_W-1:0]     wr_wide;
    logic [WIDE_W-1:0]     rd_wide;

    assign wr_wide     = WIDE_W'(cmd.push_data);
    assign mem_wr_data = wr_wide[DATA_WIDTH-1:0];
    assign rd_wide     = WIDE_W'(mem_rd_data);

    crf_ctrl #(
        .DEPTH (DEPTH)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .cmd_valid   (cmd.valid),
        .cmd_op      (cmd.op),
        .cmd_ready   (cmd.ready),
        .rsp_ready   (rsp.ready),
        .result      (result),
        .flags       (flags),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr)
    );

    crf_ram #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_ram (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign rsp.valid      = result.valid;
    assign rsp.status     = result.status;
    assign rsp.fill_count = result.fill_count;
    assign rsp.is_closed  = result.is_closed;
    assign rsp.pop_data   = result.pop_ok ? rd_wide[WORD_W-1:0] : '0;

    a_abort_closes: assert property (@(posedge clk) disable iff (!rst_n)
        flags.aborted |-> flags.closed)
        else $error("aborted without closed");

    a_full_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !(flags.full && flags.empty))
        else $error("full and empty at once");

    a_closed_sticks: assert property (@(posedge clk) disable iff (!rst_n)
        flags.closed |=> flags.closed)
        else $error("closed flag dropped");

    a_data_only_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp.valid && rsp.status != ST_OK) |-> (rsp.pop_data == '0))
        else $error("pop data on failed transaction");

endmodule

[rtl/crf_ram.sv]
module crf_ram #(
    parameter int DEPTH      = 128,
    parameter int DATA_WIDTH = 32
) (
    input  logic                     clk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [DATA_WIDTH-1:0]    wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [DATA_WIDTH-1:0]    rd_data
);

    logic [DATA_WIDTH-1:0] mem [DEPTH];
    logic [DATA_WIDTH-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/crf_ctrl.sv]
module crf_ctrl #(
    parameter int DEPTH = 128
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_wr_en,
    input  logic [crf_pkg::PROD_W-1:0]     cfg_wr_data,
    input  logic                           cmd_valid,
    input  logic [crf_pkg::OP_W-1:0]       cmd_op,
    output logic                           cmd_ready,
    input  logic                           rsp_ready,
    output crf_pkg::crf_result_t           result,
    output crf_pkg::crf_flags_t            flags,
    output logic                           mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]       mem_wr_addr,
    output logic                           mem_rd_en,
    output logic [$clog2(DEPTH)-1:0]       mem_rd_addr
);
    import crf_pkg::*;

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int CNT_W  = ADDR_W + 1;
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

    logic [ADDR_W-1:0] wp_reg, wp_next;
    logic [ADDR_W-1:0] rp_reg, rp_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [PROD_W-1:0] prod_left_reg, prod_left_next;
    logic              closed_reg, closed_next;
    logic              aborted_reg, aborted_next;
    crf_result_t       result_reg, result_next;

    logic              accept;
    logic              is_full;
    logic              is_empty;
    logic              do_clear;
    logic              do_push;
    logic              do_pop;
    logic [STATUS_W-1:0] status_res;
    logic [PROD_W-1:0] prod_dec;

    assign accept    = cmd_valid && cmd_ready;
    assign cmd_ready = !result_reg.valid || rsp_ready;
    assign is_full   = (occ_reg == FULL_CNT);
    assign is_empty  = (occ_reg == '0);
    assign prod_dec  = (prod_left_reg != '0) ? prod_left_reg - PROD_W'(1) : '0;

    always_comb
    begin
        wp_next        = wp_reg;
        rp_next        = rp_reg;
        occ_next       = occ_reg;
        prod_left_next = prod_left_reg;
        closed_next    = closed_reg;
        aborted_next   = aborted_reg;
        status_res     = ST_OK;
        do_clear       = 1'b0;
        do_push        = 1'b0;
        do_pop         = 1'b0;

        unique case (cmd_op)
            OP_PUSH:
            begin
                if (aborted_reg || closed_reg)
                begin
                    status_res = ST_CLOSED;
                end
                else if (is_full)
                begin
                    status_res = ST_FULL;
                end
                else
                begin
                    do_push  = 1'b1;
                    wp_next  = wp_reg + ADDR_W'(1);
                    occ_next = occ_reg + CNT_W'(1);
                end
            end
            OP_POP:
            begin
                if (aborted_reg)
                begin
                    status_res = ST_CLOSED;
                end
                else if (is_empty)
                begin
                    status_res = closed_reg ? ST_CLOSED : ST_EMPTY;
                end
                else
                begin
                    do_pop   = 1'b1;
                    rp_next  = rp_reg + ADDR_W'(1);
                    occ_next = occ_reg - CNT_W'(1);
                end
            end
            OP_CLOSE:
            begin
                prod_left_next = prod_dec;
                if (prod_dec == '0)
                begin
                    closed_next = 1'b1;
                end
            end
            OP_ABORT:
            begin
                aborted_next   = 1'b1;
                closed_next    = 1'b1;
                prod_left_next = '0;
            end
            OP_CLEAR:
            begin
                do_clear = 1'b1;
                wp_next  = '0;
                rp_next  = '0;
                occ_next = '0;
            end
            OP_LENGTH: ;
            default: ;
        endcase

        result_next.valid      = 1'b1;
        result_next.status     = status_res;
        result_next.fill_count = do_clear ? FILL_W'(occ_reg) : FILL_W'(occ_next);
        result_next.is_closed  = closed_next;
        result_next.pop_ok     = do_pop;
    end

    // memory ports, enabled only for an accepted transaction
    assign mem_wr_en   = accept && do_push;
    assign mem_wr_addr = wp_reg;
    assign mem_rd_en   = accept && do_pop;
    assign mem_rd_addr = rp_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg        <= '0;
            rp_reg        <= '0;
            occ_reg       <= '0;
            prod_left_reg <= PROD_RESET;
            closed_reg    <= 1'b0;
            aborted_reg   <= 1'b0;
            result_reg    <= '0;
        end
        else
        begin
            if (cfg_wr_en)
            begin
                prod_left_reg <= cfg_wr_data;
            end
            else if (accept)
            begin
                prod_left_reg <= prod_left_next;
            end

            if (accept)
            begin
                wp_reg      <= wp_next;
                rp_reg      <= rp_next;
                occ_reg     <= occ_next;
                closed_reg  <= closed_next;
                aborted_reg <= aborted_next;
                result_reg  <= result_next;
            end
            else if (rsp_ready)
            begin
                result_reg.valid <= 1'b0;
            end
        end
    end

    assign result        = result_reg;
    assign flags.closed  = closed_reg;
    assign flags.aborted = aborted_reg;
    assign flags.full    = is_full;
    assign flags.empty   = is_empty;

endmodule
